>>> src/cmos_rtc_register_file_defines.svh
// Assertion macros for the CMOS RTC register file checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CMOS_RTC_REGISTER_FILE_DEFINES_SVH
`define CMOS_RTC_REGISTER_FILE_DEFINES_SVH

// same-cycle implication
`define RTC_RF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTC_RF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rtc_rf_pkg.sv
// Shared types, register addresses and lookup functions of the CMOS RTC register file.
// No dependencies.
package rtc_rf_pkg;

    localparam logic [6:0] A_SEC      = 7'h00;
    localparam logic [6:0] A_ALM_SEC  = 7'h01;
    localparam logic [6:0] A_MIN      = 7'h02;
    localparam logic [6:0] A_ALM_MIN  = 7'h03;
    localparam logic [6:0] A_HOUR     = 7'h04;
    localparam logic [6:0] A_ALM_HOUR = 7'h05;
    localparam logic [6:0] A_WDAY     = 7'h06;
    localparam logic [6:0] A_DAY      = 7'h07;
    localparam logic [6:0] A_MON      = 7'h08;
    localparam logic [6:0] A_YEAR     = 7'h09;
    localparam logic [6:0] A_STAT_A   = 7'h0A;
    localparam logic [6:0] A_STAT_B   = 7'h0B;
    localparam logic [6:0] A_STAT_C   = 7'h0C;
    localparam logic [6:0] A_STAT_D   = 7'h0D;
    localparam logic [6:0] A_CK_FIRST = 7'h10;
    localparam logic [6:0] A_CK_HI    = 7'h2E;
    localparam logic [6:0] A_CK_LO    = 7'h2F;
    localparam logic [6:0] A_CENTURY  = 7'h32;

    localparam int CK_COUNT   = 30;
    localparam int DIV_STEPS  = 32;
    localparam int LOAD_STEPS = 8;

    localparam logic [7:0] FLAG_PERIODIC = 8'hC0;
    localparam logic [7:0] FLAG_ALARM    = 8'hA0;
    localparam logic [7:0] INDEX_READ    = 8'hFF;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_TICK  = 2'd2,
        FN_ACK   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_WRITE,
        OP_ACK,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_LOAD,
        OP_ALARM,
        OP_RD_ISSUE,
        OP_RD_CAP,
        OP_CK_STEP,
        OP_CK_HI,
        OP_CK_LO
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [5:0] cnt;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  port_sel;
        logic  idx_time;
        logic  need_ck;
        logic  elapsed_zero;
        logic  per_en;
        logic  alarm_en;
    } t_status;

    function automatic logic [7:0] bcd8(input logic [7:0] v);
        logic [15:0] p;
        logic [4:0]  t;
        logic [7:0]  u;
        p = {8'b0, v} * 16'd205;
        t = p[15:11];
        u = v - ({3'b0, t} * 8'd10);
        return {t[3:0], u[3:0]};
    endfunction

    function automatic logic [5:0] bcd_val(input logic [5:0] b);
        return ({4'b0, b[5:4]} * 6'd10) + {2'b0, b[3:0]};
    endfunction

    function automatic logic field_match(input logic [7:0] alarm, input logic [7:0] cur);
        return (alarm[7:6] != 2'b00) || (bcd_val(alarm[5:0]) == bcd_val(cur[5:0]));
    endfunction

    function automatic logic [18:0] period_interval(input logic [3:0] rate);
        logic [18:0] v;
        unique case (rate)
            4'd1, 4'd8:  v = 19'd3906;
            4'd2, 4'd9:  v = 19'd7812;
            4'd3:        v = 19'd122;
            4'd4:        v = 19'd244;
            4'd5:        v = 19'd488;
            4'd6:        v = 19'd976;
            4'd7:        v = 19'd1953;
            4'd10:       v = 19'd15625;
            4'd11:       v = 19'd31250;
            4'd12:       v = 19'd62500;
            4'd13:       v = 19'd125000;
            4'd14:       v = 19'd250000;
            4'd15:       v = 19'd500000;
            default:     v = 19'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] cmos_default(input logic [6:0] a);
        logic [7:0] v;
        unique case (a)
            7'h06:   v = 8'h01;
            7'h0A:   v = 8'h26;
            7'h0B:   v = 8'h02;
            7'h0D:   v = 8'h80;
            7'h10:   v = 8'h44;
            7'h12:   v = 8'h0F;
            7'h14:   v = 8'h4D;
            7'h15:   v = 8'h80;
            7'h16:   v = 8'h02;
            7'h2E:   v = 8'h01;
            7'h2F:   v = 8'h22;
            7'h33:   v = 8'h80;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> src/rtc_rf_if.sv
// Valid/ready channel interfaces for the CMOS RTC register file.
// No dependencies.
interface rtc_rf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        port_sel;
    logic [7:0]  write_data;
    logic [23:0] elapsed_us;
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [2:0]  cur_weekday;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;

    modport source (output valid, func, port_sel, write_data, elapsed_us, cur_second,
                    cur_minute, cur_hour, cur_weekday, cur_day, cur_month, cur_year,
                    input ready);
    modport sink (input valid, func, port_sel, write_data, elapsed_us, cur_second,
                  cur_minute, cur_hour, cur_weekday, cur_day, cur_month, cur_year,
                  output ready);
endinterface

interface rtc_rf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_taken;
    logic       nmi_enabled;

    modport source (output valid, read_data, irq_taken, nmi_enabled, input ready);
    modport sink (input valid, read_data, irq_taken, nmi_enabled, output ready);
endinterface

>>> src/rtc_rf_ctrl.sv
// Sequencing state machine of the CMOS RTC register file.
// Depends on rtc_rf_pkg.
module rtc_rf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    input  rtc_rf_pkg::t_status i_status,
    output logic                o_in_ready,
    output logic                o_push,
    output rtc_rf_pkg::t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DISP     = 13'b0000000000010,
        S_ACC      = 13'b0000000000100,
        S_DIV      = 13'b0000000001000,
        S_DIV_END  = 13'b0000000010000,
        S_LOAD     = 13'b0000000100000,
        S_ALARM    = 13'b0000001000000,
        S_RD_ISSUE = 13'b0000010000000,
        S_RD_CAP   = 13'b0000100000000,
        S_CK       = 13'b0001000000000,
        S_CK_HI    = 13'b0010000000000,
        S_CK_LO    = 13'b0100000000000,
        S_RESP     = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = '0;
        o_cmd.op   = rtc_rf_pkg::OP_NONE;
        o_cmd.cnt  = r_cnt;
        o_push     = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = rtc_rf_pkg::OP_CAPTURE;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.func)
                    rtc_rf_pkg::FN_WRITE: begin
                        o_cmd.op = rtc_rf_pkg::OP_WRITE;
                        n_state  = (i_status.port_sel && i_status.need_ck) ? S_CK : S_RESP;
                    end
                    rtc_rf_pkg::FN_READ: begin
                        n_state = (i_status.port_sel && i_status.idx_time) ? S_LOAD
                                                                          : S_RD_ISSUE;
                    end
                    rtc_rf_pkg::FN_TICK: begin
                        n_state = i_status.elapsed_zero ? S_RESP : S_ACC;
                    end
                    default: begin
                        o_cmd.op = rtc_rf_pkg::OP_ACK;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_ACC: begin
                o_cmd.op = rtc_rf_pkg::OP_ACC;
                if (i_status.per_en) begin
                    n_state = S_DIV;
                end else begin
                    n_state = i_status.alarm_en ? S_LOAD : S_RESP;
                end
            end
            S_DIV: begin
                o_cmd.op = (r_cnt == '0) ? rtc_rf_pkg::OP_DIV_INIT : rtc_rf_pkg::OP_DIV_STEP;
                if (r_cnt == 6'(rtc_rf_pkg::DIV_STEPS)) begin
                    n_state = S_DIV_END;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DIV_END: begin
                o_cmd.op = rtc_rf_pkg::OP_DIV_END;
                n_state  = i_status.alarm_en ? S_LOAD : S_RESP;
            end
            S_LOAD: begin
                o_cmd.op = rtc_rf_pkg::OP_LOAD;
                if (r_cnt == 6'(rtc_rf_pkg::LOAD_STEPS - 1)) begin
                    n_state = (i_status.func == rtc_rf_pkg::FN_READ) ? S_RD_ISSUE : S_ALARM;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_ALARM: begin
                o_cmd.op = rtc_rf_pkg::OP_ALARM;
                n_state  = S_RESP;
            end
            S_RD_ISSUE: begin
                o_cmd.op = rtc_rf_pkg::OP_RD_ISSUE;
                n_state  = S_RD_CAP;
            end
            S_RD_CAP: begin
                o_cmd.op = rtc_rf_pkg::OP_RD_CAP;
                n_state  = S_RESP;
            end
            S_CK: begin
                o_cmd.op = rtc_rf_pkg::OP_CK_STEP;
                if (r_cnt == 6'(rtc_rf_pkg::CK_COUNT)) begin
                    n_state = S_CK_HI;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_CK_HI: begin
                o_cmd.op = rtc_rf_pkg::OP_CK_HI;
                n_state  = S_CK_LO;
            end
            S_CK_LO: begin
                o_cmd.op = rtc_rf_pkg::OP_CK_LO;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/rtc_rf_dp.sv
// Datapath of the CMOS RTC register file: CMOS RAM, status shadows, divider, checksum.
// Depends on rtc_rf_pkg.
module rtc_rf_dp #(
    parameter int RAM_DEPTH = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtc_rf_pkg::t_cmd    i_cmd,
    input  logic [1:0]          i_func,
    input  logic                i_port_sel,
    input  logic [7:0]          i_write_data,
    input  logic [23:0]         i_elapsed_us,
    input  logic [5:0]          i_cur_second,
    input  logic [5:0]          i_cur_minute,
    input  logic [4:0]          i_cur_hour,
    input  logic [2:0]          i_cur_weekday,
    input  logic [4:0]          i_cur_day,
    input  logic [3:0]          i_cur_month,
    input  logic [13:0]         i_cur_year,
    output rtc_rf_pkg::t_status o_status,
    output logic [7:0]          o_read_data,
    output logic                o_irq_taken,
    output logic                o_nmi_enabled
);

    localparam int AW = $clog2(RAM_DEPTH);

    logic [7:0]  r_mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] r_valid;
    logic [7:0]  r_q;

    rtc_rf_pkg::t_func r_func;
    logic        r_port;
    logic [7:0]  r_wd;
    logic [23:0] r_elapsed;

    logic [5:0]  r_snap_sec, r_snap_min;
    logic [4:0]  r_snap_hour, r_snap_day;
    logic [2:0]  r_snap_wday;
    logic [3:0]  r_snap_mon;
    logic [13:0] r_snap_year;
    logic [7:0]  r_year_q;
    logic [6:0]  r_year_r;

    logic [6:0]  r_index;
    logic        r_nmi;
    logic [31:0] r_acc;
    logic [15:0] r_pend;
    logic [7:0]  r_reg_a, r_reg_b, r_reg_c;
    logic [7:0]  r_alm_sec, r_alm_min, r_alm_hour;
    logic [7:0]  r_res_rd;
    logic        r_res_taken;

    logic [31:0] r_dividend, r_quo;
    logic [19:0] r_rem;
    logic [12:0] r_sum;

    logic        in_range;
    logic        idx_mem_wr;
    logic [18:0] interval;
    logic [4:0]  h12;
    logic [7:0]  sec_b, min_b, hour_b, load_b;
    logic [6:0]  load_addr;
    logic        we;
    logic [6:0]  waddr, raddr;
    logic [7:0]  wdata;
    logic [19:0] trial;
    logic        ge;
    logic [32:0] acc_sum;
    logic [16:0] pend_sum;
    logic        alarm_hit;
    logic [7:0]  rd_value;

    assign in_range   = 32'(r_index) < RAM_DEPTH;
    assign idx_mem_wr = in_range && (r_index != rtc_rf_pkg::A_STAT_A)
                        && (r_index != rtc_rf_pkg::A_STAT_B)
                        && (r_index != rtc_rf_pkg::A_STAT_C)
                        && (r_index != rtc_rf_pkg::A_STAT_D);
    assign interval   = rtc_rf_pkg::period_interval(r_reg_a[3:0]);

    assign o_status.func         = r_func;
    assign o_status.port_sel     = r_port;
    assign o_status.idx_time     = in_range && (r_index <= rtc_rf_pkg::A_YEAR);
    assign o_status.need_ck      = idx_mem_wr && (r_index < rtc_rf_pkg::A_CK_HI);
    assign o_status.elapsed_zero = (r_elapsed == '0);
    assign o_status.per_en       = r_reg_b[6] && (interval != '0);
    assign o_status.alarm_en     = r_reg_b[5];

    assign o_read_data   = r_res_rd;
    assign o_irq_taken   = r_res_taken;
    assign o_nmi_enabled = r_nmi;

    always_comb begin
        if (r_snap_hour >= 5'd24) begin
            h12 = r_snap_hour - 5'd24;
        end else if (r_snap_hour >= 5'd12) begin
            h12 = r_snap_hour - 5'd12;
        end else begin
            h12 = r_snap_hour;
        end
        if (h12 == '0) begin
            h12 = 5'd12;
        end
        sec_b = rtc_rf_pkg::bcd8({2'b0, r_snap_sec});
        min_b = rtc_rf_pkg::bcd8({2'b0, r_snap_min});
        if (r_reg_b[1]) begin
            hour_b = rtc_rf_pkg::bcd8({3'b0, r_snap_hour});
        end else begin
            hour_b = rtc_rf_pkg::bcd8({3'b0, h12})
                     | ((r_snap_hour >= 5'd12) ? 8'h80 : 8'h00);
        end
    end

    always_comb begin
        case (i_cmd.cnt[2:0])
            3'd0: begin
                load_addr = rtc_rf_pkg::A_SEC;
                load_b    = sec_b;
            end
            3'd1: begin
                load_addr = rtc_rf_pkg::A_MIN;
                load_b    = min_b;
            end
            3'd2: begin
                load_addr = rtc_rf_pkg::A_HOUR;
                load_b    = hour_b;
            end
            3'd3: begin
                load_addr = rtc_rf_pkg::A_WDAY;
                load_b    = rtc_rf_pkg::bcd8({5'b0, r_snap_wday} + 8'd1);
            end
            3'd4: begin
                load_addr = rtc_rf_pkg::A_DAY;
                load_b    = rtc_rf_pkg::bcd8({3'b0, r_snap_day});
            end
            3'd5: begin
                load_addr = rtc_rf_pkg::A_MON;
                load_b    = rtc_rf_pkg::bcd8({4'b0, r_snap_mon});
            end
            3'd6: begin
                load_addr = rtc_rf_pkg::A_YEAR;
                load_b    = rtc_rf_pkg::bcd8({1'b0, r_year_r});
            end
            default: begin
                load_addr = rtc_rf_pkg::A_CENTURY;
                load_b    = rtc_rf_pkg::bcd8(r_year_q);
            end
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_index;
        wdata = r_wd;
        raddr = r_index;
        case (i_cmd.op)
            rtc_rf_pkg::OP_LOAD: begin
                we    = 1'b1;
                waddr = load_addr;
                wdata = load_b;
            end
            rtc_rf_pkg::OP_WRITE: begin
                we = r_port && idx_mem_wr;
            end
            rtc_rf_pkg::OP_CK_HI: begin
                we    = 1'b1;
                waddr = rtc_rf_pkg::A_CK_HI;
                wdata = {3'b0, r_sum[12:8]};
            end
            rtc_rf_pkg::OP_CK_LO: begin
                we    = 1'b1;
                waddr = rtc_rf_pkg::A_CK_LO;
                wdata = r_sum[7:0];
            end
            rtc_rf_pkg::OP_CK_STEP: begin
                raddr = rtc_rf_pkg::A_CK_FIRST + {1'b0, i_cmd.cnt};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign trial     = {r_rem[18:0], r_dividend[31]};
    assign ge        = trial >= {1'b0, interval};
    assign acc_sum   = {1'b0, r_acc} + {9'b0, r_elapsed};
    assign pend_sum  = {1'b0, r_pend} + {1'b0, r_quo[15:0]};
    assign alarm_hit = rtc_rf_pkg::field_match(r_alm_sec, sec_b)
                       && rtc_rf_pkg::field_match(r_alm_min, min_b)
                       && rtc_rf_pkg::field_match(r_alm_hour, hour_b);

    always_comb begin
        if (!r_port) begin
            rd_value = rtc_rf_pkg::INDEX_READ;
        end else if (!in_range) begin
            rd_value = 8'h00;
        end else if (r_index == rtc_rf_pkg::A_STAT_A) begin
            rd_value = r_reg_a;
        end else if (r_index == rtc_rf_pkg::A_STAT_B) begin
            rd_value = r_reg_b;
        end else if (r_index == rtc_rf_pkg::A_STAT_C) begin
            rd_value = r_reg_c;
        end else begin
            rd_value = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr[AW-1:0]] <= wdata;
        end
        r_q <= r_valid[raddr[AW-1:0]] ? r_mem[raddr[AW-1:0]] : rtc_rf_pkg::cmos_default(raddr);
    end

    always_ff @(posedge i_clk) begin
        r_year_q <= 8'(({18'b0, r_snap_year} * 32'd5243) >> 19);
        r_year_r <= 7'(r_snap_year - ({6'b0, r_year_q} * 14'd100));
        case (i_cmd.op)
            rtc_rf_pkg::OP_CAPTURE: begin
                r_func    <= rtc_rf_pkg::t_func'(i_func);
                r_port    <= i_port_sel;
                r_wd      <= i_write_data;
                r_elapsed <= i_elapsed_us;
            end
            rtc_rf_pkg::OP_DIV_INIT: begin
                r_dividend <= r_acc;
                r_rem      <= '0;
                r_quo      <= '0;
            end
            rtc_rf_pkg::OP_DIV_STEP: begin
                r_dividend <= {r_dividend[30:0], 1'b0};
                r_rem      <= ge ? (trial - {1'b0, interval}) : trial;
                r_quo      <= {r_quo[30:0], ge};
            end
            rtc_rf_pkg::OP_CK_STEP: begin
                if (i_cmd.cnt == '0) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= r_sum + {5'b0, r_q};
                end
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_snap_sec  <= '0;
            r_snap_min  <= '0;
            r_snap_hour <= '0;
            r_snap_wday <= '0;
            r_snap_day  <= '0;
            r_snap_mon  <= '0;
            r_snap_year <= '0;
            r_index     <= '0;
            r_nmi       <= 1'b1;
            r_acc       <= '0;
            r_pend      <= '0;
            r_reg_a     <= 8'h26;
            r_reg_b     <= 8'h02;
            r_reg_c     <= 8'h00;
            r_alm_sec   <= 8'h00;
            r_alm_min   <= 8'h00;
            r_alm_hour  <= 8'h00;
            r_res_rd    <= '0;
            r_res_taken <= 1'b0;
        end else begin
            if (we) begin
                r_valid[waddr[AW-1:0]] <= 1'b1;
            end
            case (i_cmd.op)
                rtc_rf_pkg::OP_CAPTURE: begin
                    r_res_rd    <= '0;
                    r_res_taken <= 1'b0;
                    if (rtc_rf_pkg::t_func'(i_func) == rtc_rf_pkg::FN_TICK) begin
                        r_snap_sec  <= i_cur_second;
                        r_snap_min  <= i_cur_minute;
                        r_snap_hour <= i_cur_hour;
                        r_snap_wday <= i_cur_weekday;
                        r_snap_day  <= i_cur_day;
                        r_snap_mon  <= i_cur_month;
                        r_snap_year <= i_cur_year;
                    end
                end
                rtc_rf_pkg::OP_WRITE: begin
                    if (!r_port) begin
                        r_nmi   <= ~r_wd[7];
                        r_index <= r_wd[6:0];
                    end else if (r_index == rtc_rf_pkg::A_STAT_A) begin
                        r_reg_a <= {r_reg_a[7], r_wd[6:0]};
                    end else if (r_index == rtc_rf_pkg::A_STAT_B) begin
                        r_reg_b <= {1'b0, r_wd[6:0]};
                    end else if (r_index == rtc_rf_pkg::A_ALM_SEC) begin
                        r_alm_sec <= r_wd;
                    end else if (r_index == rtc_rf_pkg::A_ALM_MIN) begin
                        r_alm_min <= r_wd;
                    end else if (r_index == rtc_rf_pkg::A_ALM_HOUR) begin
                        r_alm_hour <= r_wd;
                    end
                end
                rtc_rf_pkg::OP_ACK: begin
                    if (r_pend != '0) begin
                        r_pend      <= r_pend - 16'd1;
                        r_res_taken <= 1'b1;
                    end
                end
                rtc_rf_pkg::OP_ACC: begin
                    r_acc <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                end
                rtc_rf_pkg::OP_DIV_END: begin
                    r_acc <= {12'b0, r_rem};
                    if (r_quo != '0) begin
                        r_reg_c <= r_reg_c | rtc_rf_pkg::FLAG_PERIODIC;
                        if ((r_quo[31:16] != '0) || pend_sum[16]) begin
                            r_pend <= 16'hFFFF;
                        end else begin
                            r_pend <= pend_sum[15:0];
                        end
                    end
                end
                rtc_rf_pkg::OP_ALARM: begin
                    if (alarm_hit) begin
                        r_reg_c <= r_reg_c | rtc_rf_pkg::FLAG_ALARM;
                        if (r_pend != 16'hFFFF) begin
                            r_pend <= r_pend + 16'd1;
                        end
                    end
                end
                rtc_rf_pkg::OP_RD_CAP: begin
                    r_res_rd <= rd_value;
                    if (r_port && in_range && (r_index == rtc_rf_pkg::A_STAT_C)) begin
                        r_reg_c <= 8'h00;
                    end
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

endmodule

>>> src/cmos_rtc_register_file.sv
// Top level of the CMOS RTC register file: controller, datapath and output register.
// Depends on rtc_rf_pkg, rtc_rf_if, rtc_rf_ctrl and rtc_rf_dp.
//
//  channel  | dir | handshake    | payload
//  i_in     | in  | valid/ready  | func, port_sel, write_data, elapsed_us, cur_* time
//  o_out    | out | valid/ready  | read_data, irq_taken, nmi_enabled
//
// One transaction at a time. Reads of the time area first run the 8 steps of
// time load; data writes below the checksum bytes run a 30-byte checksum sweep
// through the single RAM read port; ticks may run a 32-step restoring divider
// for the periodic interrupt, then time load and alarm.
// Reset is synchronous; RAM defaults come from per-byte valid bits, no clearing pass.
// A waiting result sits in the output register while the next transaction is taken.
module cmos_rtc_register_file #(
    parameter int RAM_DEPTH = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtc_rf_in_if.sink      i_in,
    rtc_rf_out_if.source   o_out
);

    rtc_rf_pkg::t_cmd    cmd;
    rtc_rf_pkg::t_status status;
    logic                push;
    logic                out_free;
    logic [7:0]          dp_rd;
    logic                dp_taken;
    logic                dp_nmi;

    logic                r_out_valid;
    logic [7:0]          r_out_rd;
    logic                r_out_taken;
    logic                r_out_nmi;

    assign out_free = !r_out_valid || o_out.ready;

    rtc_rf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    rtc_rf_dp #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_in.func),
        .i_port_sel    (i_in.port_sel),
        .i_write_data  (i_in.write_data),
        .i_elapsed_us  (i_in.elapsed_us),
        .i_cur_second  (i_in.cur_second),
        .i_cur_minute  (i_in.cur_minute),
        .i_cur_hour    (i_in.cur_hour),
        .i_cur_weekday (i_in.cur_weekday),
        .i_cur_day     (i_in.cur_day),
        .i_cur_month   (i_in.cur_month),
        .i_cur_year    (i_in.cur_year),
        .o_status      (status),
        .o_read_data   (dp_rd),
        .o_irq_taken   (dp_taken),
        .o_nmi_enabled (dp_nmi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_rd    <= dp_rd;
            r_out_taken <= dp_taken;
            r_out_nmi   <= dp_nmi;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_data   = r_out_rd;
    assign o_out.irq_taken   = r_out_taken;
    assign o_out.nmi_enabled = r_out_nmi;

endmodule

>>> src/rtc_rf_checker.sv
// Port-level checker of the CMOS RTC register file, bound to the top level.
// Depends on rtc_rf_pkg and cmos_rtc_register_file_defines.svh.
`include "cmos_rtc_register_file_defines.svh"

module rtc_rf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_func,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_irq_taken
);

    logic in_hs;
    logic in_rd;

    assign in_hs = i_in_valid && i_in_ready;
    assign in_rd = in_hs && (i_in_func == rtc_rf_pkg::FN_READ);

    `RTC_RF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `RTC_RF_ASSERT_NOW(a_taken_no_data, i_out_valid && i_irq_taken, i_read_data == 8'h00, "ack with data")
    `RTC_RF_ASSERT_NEXT(a_one_at_a_time, in_hs, !i_in_ready, "second transaction taken early")
    `RTC_RF_ASSERT_NEXT(a_read_busy, in_rd, !i_out_valid || !$past(i_out_valid) || i_in_ready == 1'b0, "read not in progress")

endmodule

bind cmos_rtc_register_file rtc_rf_checker u_rtc_rf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_data (o_out.read_data),
    .i_irq_taken (o_out.irq_taken)
);

>>> tb/sv/tb.sv
// Testbench for the CMOS RTC register file: directed and random port, tick and poll traffic.
// Depends on rtc_rf_pkg, rtc_rf_if and cmos_rtc_register_file; scoreboard predicts every result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        rtc_rf_pkg::t_func func;
        logic        port_sel;
        logic [7:0]  wdata;
        logic [23:0] elapsed;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [2:0]  wday;
        logic [4:0]  day;
        logic [3:0]  mon;
        logic [13:0] year;
    } t_req;

    typedef struct {
        logic [7:0] rdata;
        logic       taken;
        logic       nmi;
    } t_rsp;

    class rtc_scoreboard;
        logic [7:0]  ram [128];
        logic [6:0]  index;
        logic        nmi_flag;
        logic [31:0] acc_us;
        logic [15:0] pending;
        int unsigned s_sec, s_min, s_hour, s_wday, s_day, s_mon, s_year;
        t_rsp        expq [$];
        int          errors;

        function logic [7:0] to_bcd(int unsigned v);
            return 8'(((v / 10) << 4) | (v % 10));
        endfunction

        function int unsigned from_bcd(logic [7:0] b);
            return b[7:4] * 10 + b[3:0];
        endfunction

        function void load_time();
            int unsigned h12;
            ram[rtc_rf_pkg::A_SEC] = to_bcd(s_sec);
            ram[rtc_rf_pkg::A_MIN] = to_bcd(s_min);
            if (ram[rtc_rf_pkg::A_STAT_B][1]) begin
                ram[rtc_rf_pkg::A_HOUR] = to_bcd(s_hour);
            end else begin
                h12 = s_hour % 12;
                if (h12 == 0) h12 = 12;
                ram[rtc_rf_pkg::A_HOUR] = to_bcd(h12);
                if (s_hour >= 12) ram[rtc_rf_pkg::A_HOUR][7] = 1'b1;
            end
            ram[rtc_rf_pkg::A_WDAY] = to_bcd(s_wday + 1);
            ram[rtc_rf_pkg::A_DAY] = to_bcd(s_day);
            ram[rtc_rf_pkg::A_MON] = to_bcd(s_mon);
            ram[rtc_rf_pkg::A_YEAR] = to_bcd(s_year % 100);
            ram[rtc_rf_pkg::A_CENTURY] = to_bcd(s_year / 100);
        endfunction

        function void refresh_sum();
            int unsigned sum;
            sum = 0;
            for (int a = rtc_rf_pkg::A_CK_FIRST; a < rtc_rf_pkg::A_CK_HI; a++) sum += ram[a];
            ram[rtc_rf_pkg::A_CK_HI] = sum[15:8];
            ram[rtc_rf_pkg::A_CK_LO] = sum[7:0];
        endfunction

        function logic alarm_hit(logic [7:0] alarm, logic [7:0] cur);
            return (alarm[7:6] != 0) ||
                   (from_bcd({2'b0, alarm[5:0]}) == from_bcd({2'b0, cur[5:0]}));
        endfunction

        function void bump(longint unsigned n);
            longint unsigned t;
            t = pending + n;
            pending = (t > 'hFFFF) ? 16'hFFFF : 16'(t);
        endfunction

        function void clear();
            foreach (ram[i]) ram[i] = 0;
            index = 0; nmi_flag = 1; acc_us = 0; pending = 0;
            s_sec = 0; s_min = 0; s_hour = 0; s_wday = 0; s_day = 0; s_mon = 0; s_year = 0;
            ram[rtc_rf_pkg::A_STAT_A] = 8'h26; ram[rtc_rf_pkg::A_STAT_B] = 8'h02;
            ram[rtc_rf_pkg::A_STAT_D] = 8'h80; ram[rtc_rf_pkg::A_CK_FIRST] = 8'h44;
            ram['h12] = 8'h0F; ram['h14] = 8'h4D; ram['h15] = 8'h80; ram['h16] = 8'h02;
            refresh_sum();
            ram['h33] = 8'h80;
            load_time();
            errors = 0;
        endfunction

        function void note_input(t_req r);
            t_rsp e;
            longint unsigned a;
            int unsigned hz, intv, n;
            logic [7:0] as_, am_, ah_;
            e.rdata = 0; e.taken = 0;
            case (r.func)
                rtc_rf_pkg::FN_WRITE: begin
                    if (!r.port_sel) begin
                        nmi_flag = !r.wdata[7];
                        index = r.wdata[6:0];
                    end else if (index == rtc_rf_pkg::A_STAT_A) begin
                        ram[rtc_rf_pkg::A_STAT_A] = {ram[rtc_rf_pkg::A_STAT_A][7], r.wdata[6:0]};
                    end else if (index == rtc_rf_pkg::A_STAT_B) begin
                        ram[rtc_rf_pkg::A_STAT_B] = {1'b0, r.wdata[6:0]};
                    end else if (index != rtc_rf_pkg::A_STAT_C &&
                                 index != rtc_rf_pkg::A_STAT_D) begin
                        ram[index] = r.wdata;
                        if (index < rtc_rf_pkg::A_CK_HI) refresh_sum();
                    end
                end
                rtc_rf_pkg::FN_READ: begin
                    if (!r.port_sel) e.rdata = rtc_rf_pkg::INDEX_READ;
                    else begin
                        if (index <= rtc_rf_pkg::A_YEAR) load_time();
                        e.rdata = ram[index];
                        if (index == rtc_rf_pkg::A_STAT_C) ram[rtc_rf_pkg::A_STAT_C] = 0;
                    end
                end
                rtc_rf_pkg::FN_TICK: begin
                    s_sec = r.sec; s_min = r.min; s_hour = r.hour; s_wday = r.wday;
                    s_day = r.day; s_mon = r.mon; s_year = r.year;
                    if (r.elapsed != 0) begin
                        a = acc_us + r.elapsed;
                        acc_us = (a > 32'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(a);
                        if (ram[rtc_rf_pkg::A_STAT_B][6]) begin
                            case (ram[rtc_rf_pkg::A_STAT_A][3:0])
                                0: hz = 0; 1, 8: hz = 256; 2, 9: hz = 128; 3: hz = 8192;
                                4: hz = 4096; 5: hz = 2048; 6: hz = 1024; 7: hz = 512;
                                10: hz = 64; 11: hz = 32; 12: hz = 16; 13: hz = 8;
                                14: hz = 4; default: hz = 2;
                            endcase
                            if (hz != 0) begin
                                intv = 1000000 / hz;
                                n = acc_us / intv;
                                if (n != 0) begin
                                    acc_us -= n * intv;
                                    bump(n);
                                    ram[rtc_rf_pkg::A_STAT_C] |= rtc_rf_pkg::FLAG_PERIODIC;
                                end
                            end
                        end
                        if (ram[rtc_rf_pkg::A_STAT_B][5]) begin
                            as_ = ram[rtc_rf_pkg::A_ALM_SEC];
                            am_ = ram[rtc_rf_pkg::A_ALM_MIN];
                            ah_ = ram[rtc_rf_pkg::A_ALM_HOUR];
                            load_time();
                            if (alarm_hit(as_, ram[rtc_rf_pkg::A_SEC]) &&
                                alarm_hit(am_, ram[rtc_rf_pkg::A_MIN]) &&
                                alarm_hit(ah_, ram[rtc_rf_pkg::A_HOUR])) begin
                                bump(1);
                                ram[rtc_rf_pkg::A_STAT_C] |= rtc_rf_pkg::FLAG_ALARM;
                            end
                        end
                    end
                end
                default: begin
                    if (pending != 0) begin
                        pending--;
                        e.taken = 1;
                    end
                end
            endcase
            e.nmi = nmi_flag;
            expq.push_back(e);
        endfunction

        function void check_result(t_rsp a);
            t_rsp e;
            if (expq.size() == 0) begin
                $display("%0t: unexpected result rd=%h", $time, a.rdata);
                errors++;
                return;
            end
            e = expq.pop_front();
            if (a.rdata !== e.rdata) begin
                $display("%0t: read_data exp %h got %h", $time, e.rdata, a.rdata);
                errors++;
            end
            if (a.taken !== e.taken) begin
                $display("%0t: irq_taken exp %b got %b", $time, e.taken, a.taken);
                errors++;
            end
            if (a.nmi !== e.nmi) begin
                $display("%0t: nmi_enabled exp %b got %b", $time, e.nmi, a.nmi);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    rtc_rf_in_if  in_ch ();
    rtc_rf_out_if out_ch ();
    rtc_scoreboard sb;
    int send_idle = 31, recv_idle = 65;
    bit hold_recv = 0;
    int n_items = 0, n_reads = 0, n_ticks = 0, n_taken = 0;

    cmos_rtc_register_file u_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0; in_ch.func = 0; in_ch.port_sel = 0; in_ch.write_data = 0;
        in_ch.elapsed_us = 0; in_ch.cur_second = 0; in_ch.cur_minute = 0; in_ch.cur_hour = 0;
        in_ch.cur_weekday = 0; in_ch.cur_day = 0; in_ch.cur_month = 0; in_ch.cur_year = 0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result('{out_ch.read_data, out_ch.irq_taken, out_ch.nmi_enabled});
                if (out_ch.irq_taken) n_taken++;
            end
            out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send(t_req r);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.func <= r.func; in_ch.port_sel <= r.port_sel; in_ch.write_data <= r.wdata;
        in_ch.elapsed_us <= r.elapsed; in_ch.cur_second <= r.sec; in_ch.cur_minute <= r.min;
        in_ch.cur_hour <= r.hour; in_ch.cur_weekday <= r.wday; in_ch.cur_day <= r.day;
        in_ch.cur_month <= r.mon; in_ch.cur_year <= r.year;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(r);
        n_items++;
        if (r.func == rtc_rf_pkg::FN_READ) n_reads++;
        if (r.func == rtc_rf_pkg::FN_TICK) n_ticks++;
    endtask

    function automatic t_req mk(rtc_rf_pkg::t_func f, logic p, logic [7:0] d);
        t_req r;
        r.func = f; r.port_sel = p; r.wdata = d; r.elapsed = 0;
        r.sec = 0; r.min = 0; r.hour = 0; r.wday = 0; r.day = 1; r.mon = 1; r.year = 0;
        return r;
    endfunction

    function automatic t_req rnd_tick(bit wild);
        t_req r;
        r = mk(rtc_rf_pkg::FN_TICK, $urandom_range(1), 8'($urandom));
        case ($urandom_range(3))
            0: r.elapsed = 0;
            1: r.elapsed = 24'($urandom);
            2: r.elapsed = 24'hFFFFFF;
            default: r.elapsed = 24'($urandom_range(70000));
        endcase
        if (wild) begin
            r.sec = 6'($urandom); r.min = 6'($urandom); r.hour = 5'($urandom);
            r.wday = 3'($urandom); r.day = 5'($urandom); r.mon = 4'($urandom);
            r.year = 14'($urandom);
        end else begin
            r.sec = $urandom_range(59); r.min = $urandom_range(59); r.hour = $urandom_range(23);
            r.wday = $urandom_range(6); r.day = $urandom_range(31, 1);
            r.mon = $urandom_range(12, 1); r.year = $urandom_range(9999);
        end
        return r;
    endfunction

    task automatic rand_item();
        int k;
        logic [7:0] v;
        k = $urandom_range(99);
        if (k < 20) begin
            send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'($urandom)));
        end else if (k < 40) begin
            send(mk(rtc_rf_pkg::FN_WRITE, 0, {1'($urandom), 7'($urandom_range(15))}));
            v = 8'($urandom);
            if ($urandom_range(3) == 0) v = {2'($urandom), 6'($urandom_range(9))};
            send(mk(rtc_rf_pkg::FN_WRITE, 1, v));
        end else if (k < 60) begin
            send(mk(rtc_rf_pkg::FN_WRITE, 0, {1'($urandom), 7'($urandom_range(15))}));
            send(mk(rtc_rf_pkg::FN_READ, 1, 8'($urandom)));
        end else if (k < 65) begin
            send(mk(rtc_rf_pkg::FN_READ, $urandom_range(1), 8'($urandom)));
        end else if (k < 85) begin
            send(rnd_tick($urandom_range(9) == 0));
        end else begin
            send(mk(rtc_rf_pkg::FN_ACK, $urandom_range(1), 8'($urandom)));
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (sb.expq.size() != 0 && guard < 100000);
    endtask

    initial begin
        t_req r;
        sb = new();
        sb.clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed
        send(mk(rtc_rf_pkg::FN_READ, 0, 0));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h8A));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_WRITE, 1, 8'hFF));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h0B));
        send(mk(rtc_rf_pkg::FN_WRITE, 1, 8'hFF));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_WRITE, 1, 8'h60));
        r = mk(rtc_rf_pkg::FN_TICK, 0, 0);
        r.elapsed = 24'hFFFFFF; r.sec = 59; r.min = 59; r.hour = 23;
        r.wday = 6; r.day = 31; r.mon = 12; r.year = 9999;
        send(r);
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h0C));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_ACK, 0, 0));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h04));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h0D));
        send(mk(rtc_rf_pkg::FN_WRITE, 1, 8'h00));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h7F));
        send(mk(rtc_rf_pkg::FN_WRITE, 1, 8'hA5));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h2D));
        send(mk(rtc_rf_pkg::FN_WRITE, 1, 8'hFF));
        send(mk(rtc_rf_pkg::FN_WRITE, 0, 8'h2E));
        send(mk(rtc_rf_pkg::FN_READ, 1, 0));
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
            recv_idle = (ph == 0) ? 65 : (ph == 1) ? 31 : 0;
            for (int i = 0; i < 340; i++) begin
                if (i == 150) begin
                    fork
                        begin
                            hold_recv = 1;
                            repeat (300) @(posedge i_clk);
                            hold_recv = 0;
                        end
                    join_none
                end
                if (i == 250) drain();
                rand_item();
            end
        end
        drain();
        repeat (100) @(posedge i_clk);
        $display("Ran %0d transactions: %0d reads, %0d ticks, %0d interrupts acknowledged.",
                 n_items, n_reads, n_ticks, n_taken);
        if (sb.errors == 0 && sb.expq.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results missing", sb.errors, sb.expq.size());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end
endmodule
